FILE: sv/f16fe_pkg.sv
`timescale 1ns / 1ps

package f16fe_pkg;

  // Longest payload a begin request may announce
  localparam int unsigned MaxPayload = 24;

  localparam logic [7:0] FrameStart = 8'h02;
  localparam logic [7:0] FrameEnd   = 8'h03;
  localparam logic [8:0] SumMod     = 9'd255;

  // Worst case burst: STX, cmd, len, check low, check high, ETX
  localparam int unsigned MaxResults = 6;
  localparam int unsigned CountW     = $clog2(MaxResults + 1);

  typedef enum logic {
    OP_BEGIN   = 1'b0,
    OP_PAYLOAD = 1'b1
  } op_e;

  typedef struct packed {
    op_e        operation;
    logic [7:0] cmd_code;
    logic [4:0] payload_length;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [CountW-1:0]          count;
    logic                       rejected;
  } burst_t;

  // a must already be reduced (below 255); b may be any byte
  function automatic logic [7:0] add_mod255(logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SumMod) begin
      s = s - SumMod;
    end
    return s[7:0];
  endfunction

endpackage

FILE: sv/f16fe_if.sv
`timescale 1ns / 1ps

interface f16fe_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] cmd_code;
  logic [4:0] payload_length;
  logic [7:0] data_byte;

  modport source (output valid, operation, cmd_code, payload_length, data_byte,
                  input ready);
  modport sink (input valid, operation, cmd_code, payload_length, data_byte,
                output ready);
endinterface

interface f16fe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       rejected;

  modport source (output valid, out_byte, run_last, rejected, input ready);
  modport sink (input valid, out_byte, run_last, rejected, output ready);
endinterface

FILE: sv/f16fe_core.sv
`timescale 1ns / 1ps

module f16fe_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  f16fe_in_if.sink           item_i,
  input  logic               free_i,
  output logic               burst_valid_o,
  output f16fe_pkg::burst_t  burst_o
);
  import f16fe_pkg::*;

  logic       item_valid_q, item_valid_d;
  item_t      item_q;
  logic       take;
  logic       accept;

  logic       frame_open_q, frame_open_d;
  logic [4:0] bytes_left_q, bytes_left_d;
  logic [7:0] low_sum_q, low_sum_d;
  logic [7:0] high_sum_q, high_sum_d;

  logic [7:0] low_cmd, low_beg, high_beg;
  logic [7:0] low_pay, high_pay;
  logic [4:0] left_dec;
  burst_t     burst;

  assign take          = item_valid_q && free_i;
  assign item_i.ready  = !item_valid_q || free_i;
  assign accept        = item_i.valid && item_i.ready;
  assign burst_valid_o = item_valid_q;
  assign burst_o       = burst;

  always_comb begin
    if (accept) begin
      item_valid_d = 1'b1;
    end else if (take) begin
      item_valid_d = 1'b0;
    end else begin
      item_valid_d = item_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.operation      <= op_e'(item_i.operation);
      item_q.cmd_code       <= item_i.cmd_code;
      item_q.payload_length <= item_i.payload_length;
      item_q.data_byte      <= item_i.data_byte;
    end
  end

  // Begin: fresh sums over cmd then length
  assign low_cmd  = add_mod255(8'd0, item_q.cmd_code);
  assign low_beg  = add_mod255(low_cmd, {3'd0, item_q.payload_length});
  assign high_beg = add_mod255(low_cmd, low_beg);

  assign low_pay  = add_mod255(low_sum_q, item_q.data_byte);
  assign high_pay = add_mod255(high_sum_q, low_pay);
  assign left_dec = bytes_left_q - 5'd1;

  always_comb begin
    frame_open_d   = frame_open_q;
    bytes_left_d   = bytes_left_q;
    low_sum_d      = low_sum_q;
    high_sum_d     = high_sum_q;
    burst.bytes    = '0;
    burst.count    = CountW'(1);
    burst.rejected = 1'b0;

    case (item_q.operation)
      OP_BEGIN: begin
        if (item_q.payload_length > 5'(MaxPayload)) begin
          frame_open_d   = 1'b0;
          bytes_left_d   = '0;
          burst.rejected = 1'b1;
        end else begin
          low_sum_d      = low_beg;
          high_sum_d     = high_beg;
          burst.bytes[0] = FrameStart;
          burst.bytes[1] = item_q.cmd_code;
          burst.bytes[2] = {3'd0, item_q.payload_length};
          if (item_q.payload_length == 5'd0) begin
            burst.bytes[3] = low_beg;
            burst.bytes[4] = high_beg;
            burst.bytes[5] = FrameEnd;
            burst.count    = CountW'(6);
            frame_open_d   = 1'b0;
            bytes_left_d   = '0;
          end else begin
            burst.count    = CountW'(3);
            frame_open_d   = 1'b1;
            bytes_left_d   = item_q.payload_length;
          end
        end
      end
      OP_PAYLOAD: begin
        if (!frame_open_q || bytes_left_q == 5'd0) begin
          burst.rejected = 1'b1;
        end else begin
          low_sum_d      = low_pay;
          high_sum_d     = high_pay;
          bytes_left_d   = left_dec;
          burst.bytes[0] = item_q.data_byte;
          if (left_dec == 5'd0) begin
            burst.bytes[1] = low_pay;
            burst.bytes[2] = high_pay;
            burst.bytes[3] = FrameEnd;
            burst.count    = CountW'(4);
            frame_open_d   = 1'b0;
          end
        end
      end
      default: begin
        burst.rejected = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
      bytes_left_q <= '0;
      low_sum_q    <= '0;
      high_sum_q   <= '0;
    end else if (take) begin
      frame_open_q <= frame_open_d;
      bytes_left_q <= bytes_left_d;
      low_sum_q    <= low_sum_d;
      high_sum_q   <= high_sum_d;
    end
  end

endmodule

FILE: sv/f16fe_ser.sv
`timescale 1ns / 1ps

module f16fe_ser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               burst_valid_i,
  input  f16fe_pkg::burst_t  burst_i,
  output logic               free_o,
  f16fe_out_if.source        result_o
);
  import f16fe_pkg::*;

  logic              valid_q, valid_d;
  burst_t            burst_q;
  logic [CountW-1:0] idx_q, idx_d;
  logic              last;
  logic              fire;
  logic              load;

  assign last   = (idx_q == CountW'(burst_q.count - CountW'(1)));
  assign fire   = valid_q && result_o.ready;
  assign free_o = !valid_q || (fire && last);
  assign load   = burst_valid_i && free_o;

  assign result_o.valid    = valid_q;
  assign result_o.out_byte = burst_q.bytes[idx_q];
  assign result_o.run_last = last;
  assign result_o.rejected = burst_q.rejected;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (fire) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      burst_q <= burst_i;
    end
  end

endmodule

FILE: sv/fletcher16_frame_encoder.sv
`timescale 1ns / 1ps

// STX/ETX frame encoder with Fletcher-16 check bytes.
// item_i takes requests: operation 0 opens a frame (cmd_code, payload_length),
// operation 1 supplies one payload byte (data_byte). result_o carries the
// frame one byte per transfer; run_last marks the final byte of a request,
// and rejected marks the single zero byte given for an over-length begin or
// a payload byte with no open frame.
// A request is held in an input register, then turned into a burst of one
// to six bytes that loads the output burst register, from which result_o
// sends them.
// Throughput: one request per cycle while each makes one byte and the
// receiver does not stall; a request that makes more bytes holds the
// output burst register until its last byte is taken.
// The input register takes the next request while a burst still drains.
// When the receiver stalls, the current byte holds and item_i drops ready
// once the input register is full.
// Reset clears the frame state, both sums and all valid flags.
module fletcher16_frame_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  f16fe_in_if.sink    item_i,
  f16fe_out_if.source result_o
);
  import f16fe_pkg::*;

  logic   burst_valid;
  logic   free;
  burst_t burst;

  f16fe_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_i),
    .free_i        (free),
    .burst_valid_o (burst_valid),
    .burst_o       (burst)
  );

  f16fe_ser u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .burst_valid_i (burst_valid),
    .burst_i       (burst),
    .free_o        (free),
    .result_o      (result_o)
  );

endmodule

FILE: sv/f16fe_checker.sv
`timescale 1ns / 1ps

module f16fe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       run_last_i,
  input logic       rejected_i
);

  // Stalled result byte holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_byte_i) && $stable(run_last_i) && $stable(rejected_i))
    else $error("stalled result changed");

  // A refusal is always a lone zero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && rejected_i |-> run_last_i && out_byte_i == 8'd0)
    else $error("rejected result not a single zero byte");

  // Nothing pending on the output means the input stage can take a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with idle output");

  assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind fletcher16_frame_encoder f16fe_checker u_f16fe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .out_byte_i  (result_o.out_byte),
  .run_last_i  (result_o.run_last),
  .rejected_i  (result_o.rejected)
);

FILE: verif/fletcher16_frame_encoder_tb.sv
`timescale 1ns / 1ps

module fletcher16_frame_encoder_tb;
  import f16fe_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       rej;
  } frame_byte_t;

  // Tracks frame state and checksums, and holds the serial bytes still owed
  class frame_scoreboard;
    logic        frame_open = 1'b0;
    logic [4:0]  bytes_left = '0;
    logic [7:0]  sum_lo = '0;
    logic [7:0]  sum_hi = '0;
    frame_byte_t owed_bytes[$];
    int unsigned taken = 0;
    int unsigned errors = 0;

    function void fold(logic [7:0] b);
      sum_lo = 8'((int'(sum_lo) + int'(b)) % int'(SumMod));
      sum_hi = 8'((int'(sum_hi) + int'(sum_lo)) % int'(SumMod));
    endfunction

    function void owe(logic [7:0] v, logic rej);
      owed_bytes.push_back('{value: v, last: 1'b0, rej: rej});
    endfunction

    function void owe_trailer();
      owe(sum_lo, 1'b0);
      owe(sum_hi, 1'b0);
      owe(FrameEnd, 1'b0);
      frame_open = 1'b0;
      bytes_left = '0;
    endfunction

    function void note_request(item_t req);
      taken++;
      if (req.operation == OP_BEGIN) begin
        if (req.payload_length > MaxPayload) begin
          // over-length: drops any open frame
          frame_open = 1'b0;
          bytes_left = '0;
          owe(8'h00, 1'b1);
        end else begin
          sum_lo = '0;
          sum_hi = '0;
          fold(req.cmd_code);
          fold({3'b000, req.payload_length});
          owe(FrameStart, 1'b0);
          owe(req.cmd_code, 1'b0);
          owe({3'b000, req.payload_length}, 1'b0);
          if (req.payload_length == 0) begin
            owe_trailer();
          end else begin
            frame_open = 1'b1;
            bytes_left = req.payload_length;
          end
        end
      end else begin
        if (!frame_open || bytes_left == 0) begin
          owe(8'h00, 1'b1);
        end else begin
          fold(req.data_byte);
          owe(req.data_byte, 1'b0);
          bytes_left = bytes_left - 5'd1;
          if (bytes_left == 0) begin
            owe_trailer();
          end
        end
      end
      owed_bytes[owed_bytes.size() - 1].last = 1'b1;
    endfunction

    function void check_result(logic [7:0] value, logic last, logic rej);
      frame_byte_t want;
      frame_byte_t got;
      got = '{value: value, last: last, rej: rej};
      if (owed_bytes.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: unexpected result byte=%02h last=%0b rej=%0b",
                   $realtime, value, last, rej);
        end
      end else begin
        want = owed_bytes.pop_front();
        if (want != got) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: mismatch exp byte=%02h last=%0b rej=%0b, got byte=%02h last=%0b rej=%0b",
                     $realtime, want.value, want.last, want.rej, value, last, rej);
          end
        end
      end
    endfunction

    function int unsigned pending();
      return owed_bytes.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  f16fe_in_if  item_if ();
  f16fe_out_if result_if ();

  fletcher16_frame_encoder u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if.sink),
    .result_o (result_if.source)
  );

  frame_scoreboard sb = new();
  int unsigned burst_left = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Monitors: inputs are driven with NBAs, so sampling here sees settled values
  always @(posedge clk_i) begin
    item_t req;
    if (rst_ni) begin
      if (item_if.valid && item_if.ready) begin
        req.operation      = op_e'(item_if.operation);
        req.cmd_code       = item_if.cmd_code;
        req.payload_length = item_if.payload_length;
        req.data_byte      = item_if.data_byte;
        sb.note_request(req);
      end
      if (result_if.valid && result_if.ready) begin
        sb.check_result(result_if.out_byte, result_if.run_last, result_if.rejected);
      end
    end
  end

  // Sender: bursts of back-to-back requests separated by random gaps
  task automatic send_request(input op_e op, input logic [7:0] cmd, input logic [4:0] len,
                              input logic [7:0] dat);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        9:          gap = $urandom_range(8, 20);
        default:    gap = $urandom_range(1, 5);
      endcase
      if (gap != 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    item_if.valid          <= 1'b1;
    item_if.operation      <= op;
    item_if.cmd_code       <= cmd;
    item_if.payload_length <= len;
    item_if.data_byte      <= dat;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
  endtask

  task automatic send_begin(input logic [7:0] cmd, input logic [4:0] len);
    send_request(OP_BEGIN, cmd, len, 8'($urandom));
  endtask

  task automatic send_payload(input logic [7:0] dat);
    send_request(OP_PAYLOAD, 8'($urandom), 5'($urandom), dat);
  endtask

  task automatic run_directed();
    send_payload(8'h55);                 // no open frame
    send_begin(8'h00, 5'd0);             // empty frame, trailer at once
    send_begin(8'hFF, 5'd0);
    send_begin(8'hFF, 5'd1);
    send_payload(8'hFF);
    send_begin(8'h12, 5'd2);
    send_payload(8'h00);
    send_begin(8'h34, 5'd1);             // abandons the open frame
    send_payload(8'h80);
    send_begin(8'h01, 5'd3);
    send_payload(8'hAA);
    send_begin(8'h7E, 5'd31);            // over-length while open
    send_payload(8'h01);
    send_begin(8'h20, 5'(MaxPayload + 1));
    send_begin(8'h5A, 5'd2);
    send_payload(8'hFE);
    send_payload(8'h7F);
    send_payload(8'h33);                 // frame already closed
    send_begin(8'hC3, 5'(MaxPayload));
    repeat (MaxPayload) send_payload(8'($urandom));
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 82) begin
        len = ($urandom_range(0, 9) == 0) ? MaxPayload : $urandom_range(0, MaxPayload);
        cut = len;
        if (len != 0 && $urandom_range(0, 9) == 0) begin
          cut = $urandom_range(0, len - 1);   // truncated frame
        end
        send_begin(8'($urandom), 5'(len));
        sent++;
        for (int unsigned i = 0; i < cut; i++) begin
          send_payload(8'($urandom));
          sent++;
        end
      end else if (kind < 91) begin
        send_begin(8'($urandom), 5'($urandom_range(MaxPayload + 1, 31)));
        sent++;
      end else begin
        send_request(op_e'($urandom_range(0, 1)), 8'($urandom), 5'($urandom),
                     8'($urandom));
        sent++;
      end
    end
  endtask

  // Receiver: changing stall modes plus one long hold-off to back up the input
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned cyc;
    logic        held;
    result_if.ready <= 1'b0;
    mode = 0;
    mode_left = 0;
    cyc = 0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (!held && sb.taken >= 120) begin
        held = 1'b1;
        result_if.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(32, 96);
        end
        mode_left--;
        case (mode)
          0:       result_if.ready <= 1'b1;
          1:       result_if.ready <= ($urandom_range(0, 3) != 0);
          2:       result_if.ready <= ($urandom_range(0, 3) == 0);
          default: result_if.ready <= (cyc % 5 != 0);
        endcase
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    item_if.valid          <= 1'b0;
    item_if.operation      <= OP_BEGIN;
    item_if.cmd_code       <= '0;
    item_if.payload_length <= '0;
    item_if.data_byte      <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random(360);
    item_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
